/* rtl/button_debounce_short_long_press_unit_assert.svh */
// Assertion macros used by the checker file of this block.
`ifndef BUTTON_DEBOUNCE_SHORT_LONG_PRESS_UNIT_ASSERT_SVH
`define BUTTON_DEBOUNCE_SHORT_LONG_PRESS_UNIT_ASSERT_SVH

// A property checked at every rising edge of clk outside reset.
`define BDSLP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define BDSLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bdslp_pkg.sv */
`default_nettype none

package bdslp_pkg;

    localparam int ACTION_BITS = 8;
    localparam int MASK_W      = 8;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX  = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd20;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd600;
    localparam logic [CFG_W-1:0] SHORT_MAX_RESET  = 16'd600;

    typedef logic [ACTION_BITS-1:0] action_t;

    typedef struct packed {
        logic [MASK_W-1:0] short_mask;
        logic [MASK_W-1:0] long_mask;
        logic [TIME_W-1:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic              event_valid;
        logic [MASK_W-1:0] event_mask;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] short_press_max_ms;
    } cfg_t;

    typedef struct packed {
        logic              seen_first;
        action_t           stable_short;
        action_t           stable_long;
        action_t           cand_short;
        action_t           cand_long;
        action_t           active_short;
        action_t           active_long;
        logic [TIME_W-1:0] cand_since;
        logic [TIME_W-1:0] press_start;
    } state_t;

endpackage

`default_nettype wire

/* rtl/bdslp_step.sv */
`default_nettype none

module bdslp_step (
    input  wire bdslp_pkg::state_t  state,
    input  wire bdslp_pkg::sample_t sample,
    input  wire bdslp_pkg::cfg_t    cfg,
    output bdslp_pkg::state_t       state_next,
    output bdslp_pkg::result_t      result
);

    always_comb
    begin
        bdslp_pkg::action_t             s;
        bdslp_pkg::action_t             l;
        bdslp_pkg::action_t             ev;
        logic [bdslp_pkg::TIME_W-1:0]   now;
        logic [bdslp_pkg::TIME_W-1:0]   elapsed;
        logic [bdslp_pkg::TIME_W-1:0]   duration;
        logic [bdslp_pkg::TIME_W-1:0]   hold_time;
        logic                           differs;
        logic                           debounced;
        logic                           release_seen;
        logic                           held;
        logic                           short_ok;
        logic                           stable_any;
        logic                           active_any;
        bdslp_pkg::state_t              st;

        s            = sample.short_mask[bdslp_pkg::ACTION_BITS-1:0];
        l            = sample.long_mask[bdslp_pkg::ACTION_BITS-1:0];
        now          = sample.now_ms;
        st           = state;
        release_seen = 1'b0;
        duration     = '0;
        elapsed      = '0;
        differs      = 1'b0;
        debounced    = 1'b0;
        ev           = '0;

        if (!state.seen_first)
        begin
            // The first sample only loads the state.
            st.seen_first   = 1'b1;
            st.stable_short = s;
            st.stable_long  = l;
            st.cand_short   = s;
            st.cand_long    = l;
            st.active_short = '0;
            st.active_long  = '0;
            st.cand_since   = now;
            st.press_start  = ((|s) || (|l)) ? now : '0;
        end
        else
        begin
            if (s != state.cand_short || l != state.cand_long)
            begin
                st.cand_short = s;
                st.cand_long  = l;
                st.cand_since = now;
            end
            differs   = (st.cand_short != state.stable_short)
                     || (st.cand_long != state.stable_long);
            elapsed   = now - st.cand_since;
            debounced = differs
                     && (elapsed >= bdslp_pkg::TIME_W'(cfg.debounce_ms));
            if (debounced)
            begin
                st.stable_short = st.cand_short;
                st.stable_long  = st.cand_long;
                if ((|st.cand_short) || (|st.cand_long))
                begin
                    // A new press, or a changed press, restarts the timing.
                    st.active_short = st.cand_short;
                    st.active_long  = st.cand_long;
                    st.press_start  = now;
                end
                else
                begin
                    release_seen = 1'b1;
                    duration     = now - state.press_start;
                end
            end
        end

        hold_time  = now - st.press_start;
        held       = hold_time >= bdslp_pkg::TIME_W'(cfg.long_press_ms);
        short_ok   = duration <= bdslp_pkg::TIME_W'(cfg.short_press_max_ms);
        stable_any = (|st.stable_short) || (|st.stable_long);
        active_any = (|st.active_short) || (|st.active_long);

        if (stable_any && active_any && held)
        begin
            ev              = st.active_long;
            st.active_short = '0;
            st.active_long  = '0;
        end
        else if (release_seen && active_any && short_ok)
        begin
            ev              = st.active_short;
            st.active_short = '0;
            st.active_long  = '0;
        end
        else if (release_seen)
        begin
            st.active_short = '0;
            st.active_long  = '0;
        end

        result.event_valid = |ev;
        result.event_mask  = bdslp_pkg::MASK_W'(ev);
        state_next         = st;
    end

endmodule

`default_nettype wire

/* rtl/button_debounce_short_long_press_unit.sv */
// Channel   Direction  Handshake            Word
// sample    in         sample_valid/stall   short_mask, long_mask, now_ms
// result    out        result_valid/stall   event_valid, event_mask
// cfg       in         cfg_valid/ready      cfg_index, cfg_data
//
// One word is accepted per cycle while sample_stall is low; its result is
// held in the result register. The sample register feeds the debounce
// and press logic, which updates the state and the result register together.
// Reset clears the tracking state and loads the default timing registers.
// A stalled result holds the pipeline; sample_stall rises only when both
// stages are full and the result is stalled.
`default_nettype none

module button_debounce_short_long_press_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                sample_valid,
    output logic                                     sample_stall,
    input  wire bdslp_pkg::sample_t                  sample,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output bdslp_pkg::result_t                       result,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bdslp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bdslp_pkg::CFG_W-1:0]         cfg_data
);

    logic                s1_valid_reg;
    logic                s1_valid_next;
    bdslp_pkg::sample_t  s1_sample_reg;
    bdslp_pkg::state_t   state_reg;
    bdslp_pkg::state_t   state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    bdslp_pkg::result_t  out_reg;
    bdslp_pkg::result_t  step_result;
    bdslp_pkg::cfg_t     cfg_reg;
    bdslp_pkg::cfg_t     cfg_next;
    logic                accept;
    logic                advance;

    bdslp_step u_step (
        .state      (state_reg),
        .sample     (s1_sample_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    assign advance      = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign sample_stall = s1_valid_reg && out_valid_reg && result_stall;
    assign accept       = sample_valid && !sample_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign cfg_ready    = 1'b1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                bdslp_pkg::REG_DEBOUNCE:   cfg_next.debounce_ms        = cfg_data;
                bdslp_pkg::REG_LONG_PRESS: cfg_next.long_press_ms      = cfg_data;
                bdslp_pkg::REG_SHORT_MAX:  cfg_next.short_press_max_ms = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg               <= 1'b0;
            out_valid_reg              <= 1'b0;
            state_reg                  <= '0;
            cfg_reg.debounce_ms        <= bdslp_pkg::DEBOUNCE_RESET;
            cfg_reg.long_press_ms      <= bdslp_pkg::LONG_PRESS_RESET;
            cfg_reg.short_press_max_ms <= bdslp_pkg::SHORT_MAX_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample;
        end
        if (advance)
        begin
            out_reg <= step_result;
        end
    end

endmodule

`default_nettype wire

/* rtl/bdslp_checker.sv */
`default_nettype none

`include "button_debounce_short_long_press_unit_assert.svh"

module bdslp_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               sample_stall,
    input wire logic               result_valid,
    input wire logic               result_stall,
    input wire bdslp_pkg::result_t result
);

    // An empty event carries no mask bits.
    `BDSLP_ASSERT(a_quiet_mask,
        (result_valid && !result.event_valid) |-> (result.event_mask == '0),
        "event mask set without an event")

    // A reported event always names at least one action.
    `BDSLP_ASSERT(a_event_nonzero,
        (result_valid && result.event_valid) |-> (result.event_mask != '0),
        "event without action bits")

    // Back pressure on samples only comes from a stalled result.
    `BDSLP_ASSERT(a_stall_source,
        sample_stall |-> (result_valid && result_stall),
        "sample stalled while the result side is free")

    // A stalled result word holds until taken.
    `BDSLP_ASSERT_NEXT(a_result_hold,
        (result_valid && result_stall), (result_valid && $stable(result)),
        "stalled result changed")

endmodule

bind button_debounce_short_long_press_unit bdslp_checker u_bdslp_checker (.*);

`default_nettype wire
